@@ src/spq_pkg.sv @@
// Shared types, codes and the order compare for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_core.
package spq_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_DFLT  = 16;

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic   func;
        value_t value;
    } cmd_t;

    typedef struct packed {
        value_t              removed_value;
        value_t              head_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        logic insert;
        logic pop;
        logic largest_first;
    } cell_ctl_t;

    // a strictly ahead of b in the current order
    function automatic logic comes_before(value_t a, value_t b, logic largest_first);
        logic res;
        if (largest_first)
        begin
            res = (a > b);
        end
        else
        begin
            res = (a < b);
        end
        return res;
    endfunction

endpackage

@@ src/sorted_priority_queue_core.sv @@
// Sorted priority queue top level: chain of spq_cell entries, entry count,
// order register and registered result beat. Depends on spq_pkg, spq_cell.
//
// Takes one command beat per clock; busy is always low. Each beat gives
// exactly one result beat, marked by done, in the cycle after it is taken,
// and the result cannot be held off. Insert and pop both finish as the
// beat is taken: every cell compares its entry with the new value at once
// and the insert position ripples through the chain, so the clock period
// grows with QUEUE_DEPTH. No clearing pass is needed after reset.
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DFLT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::cmd_t cmd,
    output logic          done,
    output spq_pkg::rsp_t result,
    input  logic          cfg_we,
    input  logic          cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               largest_first_reg;
    logic               done_reg;
    spq_pkg::rsp_t      result_reg;
    spq_pkg::rsp_t      result_next;
    spq_pkg::cell_ctl_t ctl;
    logic               accept;
    logic               full;
    logic               empty;

    spq_pkg::value_t cell_value [QUEUE_DEPTH];
    spq_pkg::value_t cell_next  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] pass;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);

    assign ctl.insert        = accept && (cmd.func == spq_pkg::FN_INSERT) && !full;
    assign ctl.pop           = accept && (cmd.func == spq_pkg::FN_POP) && !empty;
    assign ctl.largest_first = largest_first_reg;

    assign pass[0] = 1'b1;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            spq_pkg::value_t left_v;
            spq_pkg::value_t right_v;

            if (i == 0)
            begin : g_left_head
                assign left_v = cmd.value;
            end
            else
            begin : g_left
                assign left_v = cell_value[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_right_tail
                assign right_v = cell_value[i];
            end
            else
            begin : g_right
                assign right_v = cell_value[i+1];
            end

            spq_cell #(
                .IS_HEAD (i == 0)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .ins_value   (cmd.value),
                .left_value  (left_v),
                .right_value (right_v),
                .occupied    (count_reg > CW'(i)),
                .pass_in     (pass[i]),
                .pass_out    (pass[i+1]),
                .value       (cell_value[i]),
                .value_next  (cell_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - CW'(1);
        end

        result_next.removed_value = ctl.pop ? cell_value[0] : '0;
        result_next.head_value    = (count_next == '0) ? '0 : cell_next[0];
        result_next.entry_count   = spq_pkg::COUNT_W'(count_next);

        unique case (cmd.func)
            spq_pkg::FN_INSERT: result_next.status = full  ? spq_pkg::ST_FULL
                                                           : spq_pkg::ST_DONE;
            spq_pkg::FN_POP:    result_next.status = empty ? spq_pkg::ST_EMPTY
                                                           : spq_pkg::ST_DONE;
            default:            result_next.status = spq_pkg::ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            largest_first_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (cfg_we)
            begin
                largest_first_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted beat without a result beat");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == spq_pkg::ST_FULL) |-> full)
        else $error("insert dropped while queue not full");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty |-> (result.head_value == '0))
        else $error("non-zero head reported on empty queue");

    a_insert_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> !pass[QUEUE_DEPTH])
        else $error("insert position ran off the end of the chain");
`endif

endmodule

@@ src/spq_cell.sv @@
// One storage cell of the queue chain: holds an entry, compares it with the
// inserted value and shifts to or from its neighbours. Depends on spq_pkg.
module spq_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::value_t    ins_value,
    input  spq_pkg::value_t    left_value,
    input  spq_pkg::value_t    right_value,
    input  logic               occupied,
    input  logic               pass_in,
    output logic               pass_out,
    output spq_pkg::value_t    value,
    output spq_pkg::value_t    value_next
);

    spq_pkg::value_t value_reg;
    logic            ahead;
    logic            here;

    always_comb
    begin
        if (IS_HEAD)
        begin
            ahead = spq_pkg::comes_before(ins_value, value_reg, ctl.largest_first);
            here  = !occupied || ahead;
        end
        else
        begin
            ahead = spq_pkg::comes_before(value_reg, ins_value, ctl.largest_first);
            here  = pass_in && !(occupied && ahead);
        end
        pass_out = pass_in && !here;
    end

    always_comb
    begin
        priority if (ctl.insert && here)
        begin
            value_next = ins_value;
        end
        else if (ctl.insert && !pass_in)
        begin
            value_next = left_value;
        end
        else if (ctl.pop)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
